[hw/rtl/fru_tl_pkg.sv]
`timescale 1ns / 1ps

package fru_tl_pkg;

   localparam int MAX_RESULTS        = 4;
   localparam int FIFO_DEPTH_DEFAULT = 4;

   // result status codes
   typedef logic [1:0] status_type;
   localparam status_type STATUS_CHAR   = 2'd0;
   localparam status_type STATUS_EMPTY  = 2'd1;
   localparam status_type STATUS_BINARY = 2'd2;

   // type/length header type codes (bits 7:6)
   typedef logic [1:0] ftype_type;
   localparam ftype_type FTYPE_BINARY = 2'd0;
   localparam ftype_type FTYPE_BCD    = 2'd1;
   localparam ftype_type FTYPE_SIX    = 2'd2;
   localparam ftype_type FTYPE_ASCII8 = 2'd3;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] SIX_OFFSET = 8'h20;

   typedef struct packed {
      logic [7:0] character;
      status_type status;
      logic       last_of_field;
   } result_type;

   // one decoded byte: up to four results, entry 0 goes out first
   typedef struct packed {
      logic [2:0]                   count;
      result_type [MAX_RESULTS-1:0] res;
   } cmd_type;

   function automatic logic [7:0] bcd_char(input logic [3:0] nib);
      logic [7:0] ch;
      case (nib)
         4'hA:    ch = 8'h20;   // space
         4'hB:    ch = 8'h2D;   // '-'
         4'hC:    ch = 8'h2E;   // '.'
         4'hD:    ch = 8'h3A;   // ':'
         4'hE:    ch = 8'h2C;   // ','
         4'hF:    ch = 8'h5F;   // '_'
         default: ch = 8'h30 + {4'h0, nib};
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] six_char(input logic [5:0] v);
      return {2'b00, v} + SIX_OFFSET;
   endfunction

endpackage

[hw/rtl/fru_tl_front.sv]
`timescale 1ns / 1ps

module fru_tl_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                in_ready,
   input  logic [7:0]          data_byte,
   input  logic                field_start,
   output logic                push,
   output fru_tl_pkg::cmd_type cmd
);

   logic                  awaiting_ff, awaiting_in;
   fru_tl_pkg::ftype_type ftype_ff, ftype_in;
   logic [5:0]            remaining_ff, remaining_in;
   logic [3:0]            carry_ff, carry_in;
   logic [1:0]            group_ff, group_in;

   logic is_header;
   logic last;

   always_comb begin
      cmd          = '0;
      awaiting_in  = awaiting_ff;
      ftype_in     = ftype_ff;
      remaining_in = remaining_ff;
      carry_in     = carry_ff;
      group_in     = group_ff;
      last         = 1'b0;
      is_header    = field_start || awaiting_ff || (remaining_ff == 6'd0);

      if (is_header) begin
         ftype_in     = data_byte[7:6];
         remaining_in = data_byte[5:0];
         carry_in     = 4'h0;
         group_in     = 2'd0;
         if (data_byte[5:0] == 6'd0) begin
            awaiting_in = 1'b1;
            cmd.count   = 3'd1;
            cmd.res[0]  = '{8'h00, fru_tl_pkg::STATUS_EMPTY, 1'b1};
         end else begin
            awaiting_in = 1'b0;
            if (data_byte[7:6] == fru_tl_pkg::FTYPE_BINARY) begin
               cmd.count  = 3'd1;
               cmd.res[0] = '{8'h00, fru_tl_pkg::STATUS_BINARY, 1'b1};
            end
         end
      end else begin
         remaining_in = remaining_ff - 6'd1;
         last         = (remaining_in == 6'd0);
         if (last) begin
            awaiting_in = 1'b1;
         end
         case (ftype_ff)
            fru_tl_pkg::FTYPE_BINARY: begin
               cmd.count = 3'd0;   // data skipped
            end
            fru_tl_pkg::FTYPE_BCD: begin
               cmd.count  = 3'd2;
               cmd.res[0] = '{fru_tl_pkg::bcd_char(data_byte[7:4]),
                              fru_tl_pkg::STATUS_CHAR, 1'b0};
               cmd.res[1] = '{fru_tl_pkg::bcd_char(data_byte[3:0]),
                              fru_tl_pkg::STATUS_CHAR, last};
            end
            fru_tl_pkg::FTYPE_SIX: begin
               case (group_ff)
                  2'd0: begin
                     carry_in   = {2'b00, data_byte[7:6]};
                     group_in   = 2'd1;
                     cmd.count  = 3'd1;
                     cmd.res[0] = '{fru_tl_pkg::six_char(data_byte[5:0]),
                                    fru_tl_pkg::STATUS_CHAR, 1'b0};
                     if (last) begin
                        // pad the partial group out to four characters
                        cmd.count  = 3'd4;
                        cmd.res[1] = '{fru_tl_pkg::six_char({4'h0, data_byte[7:6]}),
                                       fru_tl_pkg::STATUS_CHAR, 1'b0};
                        cmd.res[2] = '{fru_tl_pkg::CHAR_SPACE,
                                       fru_tl_pkg::STATUS_CHAR, 1'b0};
                        cmd.res[3] = '{fru_tl_pkg::CHAR_SPACE,
                                       fru_tl_pkg::STATUS_CHAR, 1'b1};
                     end
                  end
                  2'd1: begin
                     carry_in   = data_byte[7:4];
                     group_in   = 2'd2;
                     cmd.count  = 3'd1;
                     cmd.res[0] = '{fru_tl_pkg::six_char({data_byte[3:0], carry_ff[1:0]}),
                                    fru_tl_pkg::STATUS_CHAR, 1'b0};
                     if (last) begin
                        cmd.count  = 3'd3;
                        cmd.res[1] = '{fru_tl_pkg::six_char({2'b00, data_byte[7:4]}),
                                       fru_tl_pkg::STATUS_CHAR, 1'b0};
                        cmd.res[2] = '{fru_tl_pkg::CHAR_SPACE,
                                       fru_tl_pkg::STATUS_CHAR, 1'b1};
                     end
                  end
                  default: begin
                     carry_in   = 4'h0;
                     group_in   = 2'd0;
                     cmd.count  = 3'd2;
                     cmd.res[0] = '{fru_tl_pkg::six_char({data_byte[1:0], carry_ff}),
                                    fru_tl_pkg::STATUS_CHAR, 1'b0};
                     cmd.res[1] = '{fru_tl_pkg::six_char(data_byte[7:2]),
                                    fru_tl_pkg::STATUS_CHAR, last};
                  end
               endcase
            end
            default: begin
               cmd.count  = 3'd1;
               cmd.res[0] = '{data_byte, fru_tl_pkg::STATUS_CHAR, last};
            end
         endcase
         if (last) begin
            carry_in = 4'h0;
            group_in = 2'd0;
         end
      end
   end

   assign push = in_valid && in_ready && (cmd.count != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff  <= 1'b1;
         ftype_ff     <= fru_tl_pkg::FTYPE_BINARY;
         remaining_ff <= 6'd0;
         carry_ff     <= 4'h0;
         group_ff     <= 2'd0;
      end else if (in_valid && in_ready) begin
         awaiting_ff  <= awaiting_in;
         ftype_ff     <= ftype_in;
         remaining_ff <= remaining_in;
         carry_ff     <= carry_in;
         group_ff     <= group_in;
      end
   end

endmodule

[hw/rtl/fru_tl_fifo.sv]
`timescale 1ns / 1ps

module fru_tl_fifo #(
   parameter int DEPTH = fru_tl_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fru_tl_pkg::cmd_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output fru_tl_pkg::cmd_type pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   fru_tl_pkg::cmd_type mem_ff [DEPTH];
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_idx_ff];

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (push) begin
         wr_idx_in = (wr_idx_ff == AW'(DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
      end
      if (pop) begin
         rd_idx_in = (rd_idx_ff == AW'(DEPTH - 1)) ? '0 : rd_idx_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_idx_ff] <= push_data;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule

[hw/rtl/fru_tl_back.sv]
`timescale 1ns / 1ps

module fru_tl_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_not_empty,
   input  fru_tl_pkg::cmd_type q_data,
   output logic                q_pop,
   output logic                out_valid,
   input  logic                out_ready,
   output fru_tl_pkg::result_type out_res
);

   fru_tl_pkg::cmd_type cmd_ff, cmd_in;
   logic                valid_ff, valid_in;
   logic [1:0]          pos_ff, pos_in;
   logic                done;

   assign out_valid = valid_ff;
   assign out_res   = cmd_ff.res[pos_ff];
   assign done      = valid_ff && out_ready && (({1'b0, pos_ff} + 3'd1) == cmd_ff.count);
   assign q_pop     = q_not_empty && (!valid_ff || done);

   always_comb begin
      cmd_in   = cmd_ff;
      valid_in = valid_ff;
      pos_in   = pos_ff;
      if (q_pop) begin
         cmd_in   = q_data;
         valid_in = 1'b1;
         pos_in   = 2'd0;
      end else if (done) begin
         valid_in = 1'b0;
         pos_in   = 2'd0;
      end else if (valid_ff && out_ready) begin
         pos_in = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ({1'b0, pos_ff} < cmd_ff.count))
      else $error("result index past command count");

   a_status_closes: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && out_res.status != fru_tl_pkg::STATUS_CHAR)
         |-> (out_res.last_of_field && out_res.character == 8'h00))
      else $error("status beat not a closing zero beat");

endmodule

[hw/rtl/fru_type_length_field_decoder_core.sv]
`timescale 1ns / 1ps
// FRU type/length field decoder.
// req channel: one FRU area byte per beat. req_tuser high forces the byte to
// be taken as a type/length header; otherwise a header is expected after
// reset and after each field ends.
// rsp channel: one decoded character or status per beat, rsp_tlast closing
// each field. Status beats (empty field, binary field) carry a zero char.
// A byte yields zero to four beats: BCD plus two, 6-bit ASCII one to four
// (a partial last group is padded with spaces), 8-bit ASCII one.
// A byte's first beat reaches rsp after it is written to the queue memory and
// then loaded into the back-end command register.
// Throughput: req takes one byte per cycle while the command queue has room;
// rsp gives one beat per cycle while rsp_tready is high, bound by the single
// output port of the back end.
// Stall: rsp_tready low holds the current beat; the queue (FIFO_DEPTH
// commands, one per byte that yields beats) keeps taking bytes until full,
// then req_tready drops.
// Reset: synchronous, clears decoder state (expect header), queue, output.
module fru_type_length_field_decoder_core #(
   parameter int FIFO_DEPTH = fru_tl_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tuser,    // [0] field_start
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] character
   output logic [1:0] rsp_tuser,    // [1:0] status
   output logic       rsp_tlast     // last_of_field
);

   logic                   push;
   fru_tl_pkg::cmd_type    push_cmd;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_not_empty;
   fru_tl_pkg::cmd_type    q_data;
   fru_tl_pkg::result_type out_res;

   assign req_tready = !q_full;

   // front: header tracking and per-byte decode into a command
   fru_tl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .data_byte   (req_tdata),
      .field_start (req_tuser),
      .push        (push),
      .cmd         (push_cmd)
   );

   fru_tl_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   // back: serializes each command into rsp beats
   fru_tl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_res     (out_res)
   );

   assign rsp_tdata = out_res.character;
   assign rsp_tuser = out_res.status;
   assign rsp_tlast = out_res.last_of_field;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int  CYCLE_LIMIT   = 200000;
   localparam int  RANDOM_BYTES  = 130;
   localparam int  HOLD_CYCLES   = 160;
   localparam int  IDLE_PERCENT  = 35;
   // BCD plus glyphs, nibble n sits at bits [8n+7:8n]
   localparam logic [8*16-1:0] BCD_GLYPHS = "_,:.- 9876543210";

   // Tracks the field decoder state and queues the characters/status beats
   // each accepted byte should produce.
   class fru_char_scoreboard;
      fru_tl_pkg::result_type expected_beats[$];
      int                     failures;
      logic                   expecting_header = 1'b1;
      fru_tl_pkg::ftype_type  cur_type         = fru_tl_pkg::FTYPE_BINARY;
      logic [5:0]             remaining        = '0;
      logic [3:0]             leftover         = '0;
      logic [1:0]             grp_pos          = '0;

      function void push(logic [7:0] ch, fru_tl_pkg::status_type st, logic last);
         fru_tl_pkg::result_type r;
         r.character     = ch;
         r.status        = st;
         r.last_of_field = last;
         expected_beats.push_back(r);
      endfunction

      function logic [7:0] six_ascii(logic [5:0] v);
         return {2'b00, v} + 8'h20;
      endfunction

      function void note_byte(logic [7:0] b, logic fs);
         logic       closing;
         logic [5:0] c;
         if (fs || expecting_header || remaining == 0) begin
            cur_type  = fru_tl_pkg::ftype_type'(b[7:6]);
            remaining = b[5:0];
            leftover  = '0;
            grp_pos   = '0;
            if (remaining == 0) begin
               expecting_header = 1'b1;
               push(8'h00, fru_tl_pkg::STATUS_EMPTY, 1'b1);
            end else begin
               expecting_header = 1'b0;
               if (cur_type == fru_tl_pkg::FTYPE_BINARY) begin
                  push(8'h00, fru_tl_pkg::STATUS_BINARY, 1'b1);
               end
            end
            return;
         end
         remaining = remaining - 6'd1;
         closing   = (remaining == 0);
         if (closing) expecting_header = 1'b1;
         case (cur_type)
            fru_tl_pkg::FTYPE_BCD: begin
               push(BCD_GLYPHS[8*b[7:4] +: 8], fru_tl_pkg::STATUS_CHAR, 1'b0);
               push(BCD_GLYPHS[8*b[3:0] +: 8], fru_tl_pkg::STATUS_CHAR, closing);
            end
            fru_tl_pkg::FTYPE_SIX: begin
               // three bytes -> four 6-bit chars, little-endian
               if (grp_pos == 2'd0) begin
                  leftover = {2'b00, b[7:6]};
                  grp_pos  = 2'd1;
                  push(six_ascii(b[5:0]), fru_tl_pkg::STATUS_CHAR, 1'b0);
                  if (closing) begin
                     push(six_ascii({4'b0000, leftover[1:0]}),
                          fru_tl_pkg::STATUS_CHAR, 1'b0);
                     push(fru_tl_pkg::CHAR_SPACE, fru_tl_pkg::STATUS_CHAR, 1'b0);
                     push(fru_tl_pkg::CHAR_SPACE, fru_tl_pkg::STATUS_CHAR, 1'b1);
                  end
               end else if (grp_pos == 2'd1) begin
                  c        = {b[3:0], leftover[1:0]};
                  leftover = b[7:4];
                  grp_pos  = 2'd2;
                  push(six_ascii(c), fru_tl_pkg::STATUS_CHAR, 1'b0);
                  if (closing) begin
                     push(six_ascii({2'b00, leftover}), fru_tl_pkg::STATUS_CHAR, 1'b0);
                     push(fru_tl_pkg::CHAR_SPACE, fru_tl_pkg::STATUS_CHAR, 1'b1);
                  end
               end else begin
                  c        = {b[1:0], leftover};
                  leftover = '0;
                  grp_pos  = 2'd0;
                  push(six_ascii(c), fru_tl_pkg::STATUS_CHAR, 1'b0);
                  push(six_ascii(b[7:2]), fru_tl_pkg::STATUS_CHAR, closing);
               end
            end
            fru_tl_pkg::FTYPE_ASCII8: push(b, fru_tl_pkg::STATUS_CHAR, closing);
            default: ;   // binary data bytes are skipped
         endcase
         if (closing) begin
            leftover = '0;
            grp_pos  = '0;
         end
      endfunction

      function void check_beat(logic [7:0] ch, logic [1:0] st, logic last);
         fru_tl_pkg::result_type want;
         if (expected_beats.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("rsp beat with nothing pending: char=%h status=%0d last=%b",
                        ch, st, last);
            return;
         end
         want = expected_beats.pop_front();
         if (ch !== want.character || st !== want.status ||
             last !== want.last_of_field) begin
            failures++;
            if (failures <= 10)
               $display("rsp mismatch: exp char %h status %0d last %b, got %h %0d %b",
                        want.character, want.status, want.last_of_field, ch, st, last);
         end
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tuser  = 1'b0;
   logic       rsp_tready = 1'b0;
   logic       req_tready;
   logic       rsp_tvalid;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   fru_char_scoreboard sb = new;

   int   cycle_count = 0;
   int   byte_count  = 0;    // accepted req beats
   logic idle_on     = 1'b1; // random gaps on both sides
   int   holds_asked = 0;    // bumped by stimulus to start a long rsp stall
   int   holds_done  = 0;
   int   hold_left   = 0;
   logic field_open  = 1'b0; // a field may still be in progress

   always #2 clock = ~clock;

   fru_type_length_field_decoder_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** fru_type_length_field_decoder_core: FAILED **");
         $finish;
      end
   end

   // Result monitor: every rsp beat is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_beat(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Receiver: random back-pressure, or a long hold when stimulus asks for one
   // so the command queue fills and req_tready drops.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         holds_done <= holds_asked;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   // tvalid stays high between back-to-back beats.
   task automatic send_byte(input logic [7:0] b, input logic fs);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= fs;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(b, fs);
      byte_count++;
      @(negedge clock);
   endtask

   // One field with random content; sometimes cut short so the next header
   // has to force a restart.
   task automatic send_random_field();
      logic [1:0] kind;
      int         len;
      int         roll;
      int         cut;
      kind = 2'($urandom_range(3));
      roll = $urandom_range(99);
      if (roll < 8)       len = 0;
      else if (roll < 93) len = $urandom_range(7, 1);
      else                len = $urandom_range(63, 8);
      send_byte({kind, 6'(len)}, field_open ? 1'b1 : 1'($urandom_range(1)));
      cut = len;
      if (len > 1 && $urandom_range(99) < 10) cut = $urandom_range(len - 1, 1);
      for (int i = 0; i < cut; i++) send_byte(8'($urandom), 1'b0);
      field_open = (cut != len);
   endtask

   initial begin
      int start_count;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed ---
      // empty field of each type
      send_byte(8'h00, 1'b1);
      send_byte(8'h40, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hC0, 1'b0);
      // binary field: status beat, data skipped
      send_byte(8'h02, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      // BCD plus, both nibbles from the punctuation half of the table
      send_byte(8'h41, 1'b0);
      send_byte(8'hAF, 1'b0);
      // 6-bit ASCII: one-, two- and three-byte groups (padding cases)
      send_byte(8'h81, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h83, 1'b0);
      send_byte(8'h29, 1'b0);
      send_byte(8'hDE, 1'b0);
      send_byte(8'hFC, 1'b0);
      // 8-bit ASCII, byte extremes
      send_byte(8'hC2, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      // header forced in the middle of a field
      send_byte(8'hC5, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h41, 1'b1);
      send_byte(8'h99, 1'b0);

      // --- random ---
      start_count = byte_count;
      while (byte_count < start_count + RANDOM_BYTES) begin
         if (byte_count >= start_count + 20 && holds_asked == 0)
            holds_asked = 1;
         idle_on = !(byte_count >= start_count + 60 && byte_count < start_count + 100);
         if ($urandom_range(99) < 5) begin
            // noise byte, state afterwards is anyone's guess
            send_byte(8'($urandom), 1'($urandom_range(1)));
            field_open = 1'b1;
         end else begin
            send_random_field();
         end
      end
      idle_on    = 1'b1;
      req_tvalid <= 1'b0;

      // drain, then give stray beats a chance to show
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("** fru_type_length_field_decoder_core: PASSED **");
      else
         $display("** fru_type_length_field_decoder_core: FAILED **");
      $finish;
   end

endmodule
